/* rtl/core/etc_pkg.sv */
// Shared constants and helpers for the encoder tuning controller.
// No dependencies; imported by the controller core.
package etc_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_LOWER_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_UPPER_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_DEBOUNCE_TICKS = 2'd2;
  localparam logic [1:0] CFG_START_FREQ     = 2'd3;

  // Reset values of the configuration registers and of the tuning register
  localparam logic [31:0] LOWER_LIMIT_RESET = 32'd1000000;
  localparam logic [31:0] UPPER_LIMIT_RESET = 32'd30000000;
  localparam logic [15:0] DEBOUNCE_RESET    = 16'd50;
  localparam logic [31:0] START_FREQ_RESET  = 32'd7000000;

  // Bit i set when transition code i is a legal quadrature step
  localparam logic [15:0] VALID_CODE_MASK = 16'h6996;

  // Histories and final codes that mark one full detent
  localparam logic [7:0] HIST_UP   = 8'h2b;
  localparam logic [3:0] CODE_UP   = 4'h0b;
  localparam logic [7:0] HIST_DOWN = 8'h17;
  localparam logic [3:0] CODE_DOWN = 4'h07;

  // Movement codes on the result
  typedef enum logic [1:0] {
    MOVE_NONE = 2'd0,
    MOVE_UP   = 2'd1,
    MOVE_DOWN = 2'd2
  } move_t;

  // Tuning steps
  localparam logic [13:0] STEP_10    = 14'd10;
  localparam logic [13:0] STEP_100   = 14'd100;
  localparam logic [13:0] STEP_1000  = 14'd1000;
  localparam logic [13:0] STEP_10000 = 14'd10000;

  // Step selected by the step index
  function automatic logic [13:0] step_value(input logic [1:0] idx);
    logic [13:0] val;
    case (idx)
      2'd0:    val = STEP_10;
      2'd1:    val = STEP_100;
      2'd2:    val = STEP_1000;
      default: val = STEP_10000;
    endcase
    return val;
  endfunction

endpackage

/* rtl/core/encoder_tuning_controller_core.sv */
// Encoder tuning controller core: quadrature decode, limited tuning and step button.
// Depends on etc_pkg for codes, reset values and the step table.
//
// One sample beat of pins A, B and the button is taken per cycle, and its result
// beat is loaded into the output register as it is taken. An input beat is taken in
// every cycle unless the output register holds a result that is stalled; all work
// for a beat is one table lookup, one add or subtract and two compares feeding the
// state and result registers. A write to start_frequency has no effect, since the
// tuning register resets to START_FREQ_RESET and no register holds a start value.
module encoder_tuning_controller_core
  import etc_pkg::*;
#(
  parameter int FREQ_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // sample channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        pin_a,
  input  logic        pin_b,
  input  logic        button_level,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] frequency,
  output logic [13:0] step_size,
  output logic [1:0]  movement
);

  // configuration registers
  logic [31:0] lower_limit;
  logic [31:0] upper_limit;
  logic [15:0] debounce_ticks;

  // working state
  logic [3:0]           transition_code;
  logic [7:0]           valid_history;
  logic [FREQ_BITS-1:0] tuned_frequency;
  logic [13:0]          current_step;
  logic [1:0]           next_step_index;
  logic [15:0]          stable_count;
  logic                 previous_raw_button;
  logic                 accepted_button;

  // next values
  logic [3:0]           transition_code_next;
  logic [7:0]           valid_history_next;
  logic [FREQ_BITS-1:0] tuned_frequency_next;
  logic [13:0]          current_step_next;
  logic [1:0]           next_step_index_next;
  logic [15:0]          stable_count_next;
  logic                 accepted_button_next;
  move_t                movement_next;

  logic                 accept;
  logic [FREQ_BITS-1:0] lo;
  logic [FREQ_BITS-1:0] hi;
  logic [FREQ_BITS-1:0] step_ext;
  logic [FREQ_BITS-1:0] sum;
  logic [FREQ_BITS-1:0] diff;

  // take a beat whenever the result register is free or drains this cycle
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign lo       = FREQ_BITS'(lower_limit);
  assign hi       = FREQ_BITS'(upper_limit);
  assign step_ext = FREQ_BITS'(current_step);
  assign sum      = tuned_frequency + step_ext;
  assign diff     = tuned_frequency - step_ext;

  // decode the encoder and tune
  always_comb begin
    transition_code_next = {transition_code[1:0], pin_a, pin_b};
    valid_history_next   = valid_history;
    tuned_frequency_next = tuned_frequency;
    movement_next        = MOVE_NONE;
    if (VALID_CODE_MASK[transition_code_next]) begin
      valid_history_next = {valid_history[3:0], transition_code_next};
      if (valid_history_next == HIST_UP && transition_code_next == CODE_UP) begin
        tuned_frequency_next = (sum < lo) ? hi : sum;
        movement_next        = MOVE_UP;
      end else if (valid_history_next == HIST_DOWN && transition_code_next == CODE_DOWN) begin
        tuned_frequency_next = (diff > hi) ? lo : diff;
        movement_next        = MOVE_DOWN;
      end
    end
  end

  // debounce the button and advance the step on a press
  always_comb begin
    current_step_next    = current_step;
    next_step_index_next = next_step_index;
    accepted_button_next = accepted_button;
    if (button_level != previous_raw_button) begin
      stable_count_next = '0;
    end else if (stable_count != 16'hffff) begin
      stable_count_next = stable_count + 16'd1;
    end else begin
      stable_count_next = stable_count;
    end
    if (stable_count_next > debounce_ticks) begin
      if (accepted_button && !button_level) begin
        current_step_next    = step_value(next_step_index);
        next_step_index_next = next_step_index + 2'd1;
      end
      accepted_button_next = button_level;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_limit    <= LOWER_LIMIT_RESET;
      upper_limit    <= UPPER_LIMIT_RESET;
      debounce_ticks <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOWER_LIMIT:    lower_limit    <= cfg_data;
        CFG_UPPER_LIMIT:    upper_limit    <= cfg_data;
        CFG_DEBOUNCE_TICKS: debounce_ticks <= cfg_data[15:0];
        CFG_START_FREQ:     ;
        default:            ;
      endcase
    end
  end

  // advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      transition_code     <= '0;
      valid_history       <= '0;
      tuned_frequency     <= FREQ_BITS'(START_FREQ_RESET);
      current_step        <= STEP_10;
      next_step_index     <= '0;
      stable_count        <= '0;
      previous_raw_button <= 1'b1;
      accepted_button     <= 1'b1;
    end else if (accept) begin
      transition_code     <= transition_code_next;
      valid_history       <= valid_history_next;
      tuned_frequency     <= tuned_frequency_next;
      current_step        <= current_step_next;
      next_step_index     <= next_step_index_next;
      stable_count        <= stable_count_next;
      previous_raw_button <= button_level;
      accepted_button     <= accepted_button_next;
    end
  end

  // result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frequency <= 32'(tuned_frequency_next);
      step_size <= current_step_next;
      movement  <= movement_next;
    end
  end

  // the step always holds one of the four table values
  assert property (@(posedge clk) disable iff (rst)
    current_step == STEP_10 || current_step == STEP_100 ||
    current_step == STEP_1000 || current_step == STEP_10000)
    else $error("step left the step table");

  // the step only changes on an accepted beat
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && current_step != $past(current_step) |-> $past(accept))
    else $error("step changed without an input beat");

  // a shown result never carries an undefined movement code
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> movement != 2'd3)
    else $error("illegal movement code");

  // tuning only happens together with a reported movement
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(accept) && tuned_frequency != $past(tuned_frequency)
      |-> movement != MOVE_NONE)
    else $error("frequency moved without a movement report");

endmodule
